[rtl/smsp_pkg.sv]
// smsp_pkg: shared widths, limits, controller state and command/status types
// for the spectrum magnitude, shift and peak block. No dependencies.
package smsp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int IDX_W      = 10;
    localparam int MAG_W      = 16;
    localparam int HALF_W     = 10;
    localparam int MAX_BINS   = 1024;
    localparam int HALF_MAX   = MAX_BINS / 2;
    localparam int RAD_W      = 2 * SAMPLE_W;
    localparam int REM_W      = MAG_W + 2;
    localparam int STEP_W     = $clog2(MAG_W);
    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(HALF_MAX);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(MAG_W - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQ_A = 6'b000010,
        ST_SQ_B = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    typedef struct packed {
        logic capture;
        logic square_a;
        logic square_b;
        logic sum;
        logic root_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic root_last;
        logic out_free;
    } status_t;

endpackage

[rtl/smsp_ctrl.sv]
// smsp_ctrl: sequencer for one bin: capture, two squarings, sum,
// bit-serial square root, then hand-off to the output register. Uses smsp_pkg.
module smsp_ctrl
    import smsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQ_A;
                end
            end
            ST_SQ_A:
            begin
                cmd.square_a = 1'b1;
                state_next   = ST_SQ_B;
            end
            ST_SQ_B:
            begin
                cmd.square_b = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/smsp_datapath.sv]
// smsp_datapath: half-size register, bin counter and shift, squaring,
// square-root iteration, running peak and output register. Uses smsp_pkg.
module smsp_datapath
    import smsp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [HALF_W-1:0]          cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] re,
    input  logic signed [SAMPLE_W-1:0] im,
    input  cmd_t                       cmd,
    output status_t                    status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [IDX_W-1:0]           bin_index,
    output logic [MAG_W-1:0]           magnitude,
    output logic                       frame_end,
    output logic [IDX_W-1:0]           peak_index,
    output logic [MAG_W-1:0]           peak_magnitude
);

    logic [HALF_W-1:0]   half_reg;
    logic [IDX_W-1:0]    bin_cnt_reg;
    logic [MAG_W-1:0]    peak_val_reg;
    logic [IDX_W-1:0]    peak_pos_reg;

    logic [SAMPLE_W-1:0] a_reg;
    logic [SAMPLE_W-1:0] b_reg;
    logic [RAD_W-1:0]    prod_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [MAG_W-1:0]    root_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic                end_reg;
    logic                first_reg;

    logic                out_valid_reg;
    logic [IDX_W-1:0]    bin_index_reg;
    logic [MAG_W-1:0]    magnitude_reg;
    logic                frame_end_reg;
    logic [IDX_W-1:0]    peak_index_reg;
    logic [MAG_W-1:0]    peak_magnitude_reg;

    logic [HALF_W-1:0]   half_eff;
    logic [IDX_W:0]      last_bin;
    logic [IDX_W:0]      pos_wide;
    logic                at_end;
    logic [SAMPLE_W-1:0] abs_re;
    logic [SAMPLE_W-1:0] abs_im;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic                take;
    logic [MAG_W-1:0]    peak_base;
    logic                new_peak;
    logic [MAG_W-1:0]    peak_val_next;
    logic [IDX_W-1:0]    peak_pos_next;

    always_comb
    begin
        if (half_reg == '0)
        begin
            half_eff = HALF_W'(1);
        end
        else if (half_reg > HALF_W'(HALF_MAX))
        begin
            half_eff = HALF_W'(HALF_MAX);
        end
        else
        begin
            half_eff = half_reg;
        end
        last_bin = {half_eff, 1'b0} - (IDX_W+1)'(1);
        at_end   = ({1'b0, bin_cnt_reg} >= last_bin);
        if ({1'b0, bin_cnt_reg} < (IDX_W+1)'(half_eff))
        begin
            pos_wide = {1'b0, bin_cnt_reg} + (IDX_W+1)'(half_eff);
        end
        else
        begin
            pos_wide = {1'b0, bin_cnt_reg} - (IDX_W+1)'(half_eff);
        end
        abs_re = re[SAMPLE_W-1] ? SAMPLE_W'(-re) : SAMPLE_W'(re);
        abs_im = im[SAMPLE_W-1] ? SAMPLE_W'(-im) : SAMPLE_W'(im);

        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        take   = (rem_sh >= trial);

        peak_base = first_reg ? '0 : peak_val_reg;
        new_peak  = (root_reg > peak_base);
        if (new_peak)
        begin
            peak_val_next = root_reg;
            peak_pos_next = pos_reg;
        end
        else
        begin
            peak_val_next = peak_base;
            peak_pos_next = first_reg ? '0 : peak_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg      <= HALF_RESET;
            bin_cnt_reg   <= '0;
            peak_val_reg  <= '0;
            peak_pos_reg  <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                half_reg <= cfg_wr_data;
            end
            if (cmd.capture)
            begin
                bin_cnt_reg <= at_end ? '0 : bin_cnt_reg + IDX_W'(1);
            end
            if (cmd.sum)
            begin
                step_reg <= '0;
            end
            else if (cmd.root_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.publish)
            begin
                peak_val_reg  <= peak_val_next;
                peak_pos_reg  <= peak_pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_reg     <= abs_re;
            b_reg     <= abs_im;
            pos_reg   <= pos_wide[IDX_W-1:0];
            end_reg   <= at_end;
            first_reg <= (bin_cnt_reg == '0);
        end
        if (cmd.square_a)
        begin
            prod_reg <= RAD_W'(a_reg) * RAD_W'(a_reg);
        end
        if (cmd.square_b)
        begin
            rad_reg  <= prod_reg;
            prod_reg <= RAD_W'(b_reg) * RAD_W'(b_reg);
        end
        if (cmd.sum)
        begin
            rad_reg  <= rad_reg + prod_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[REM_W-1:0];
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
        if (cmd.publish)
        begin
            bin_index_reg      <= pos_reg;
            magnitude_reg      <= root_reg;
            frame_end_reg      <= end_reg;
            peak_index_reg     <= end_reg ? peak_pos_next : '0;
            peak_magnitude_reg <= end_reg ? peak_val_next : '0;
        end
    end

    assign status.root_last = (step_reg == STEP_LAST);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign bin_index      = bin_index_reg;
    assign magnitude      = magnitude_reg;
    assign frame_end      = frame_end_reg;
    assign peak_index     = peak_index_reg;
    assign peak_magnitude = peak_magnitude_reg;

endmodule

[rtl/spectrum_magnitude_shift_peak.sv]
// spectrum_magnitude_shift_peak: top level, joins smsp_ctrl and smsp_datapath.
// Depends on smsp_pkg, smsp_ctrl, smsp_datapath.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   input    | in_valid / in_ready   | re, im
//   output   | out_valid / out_ready | bin_index, magnitude, frame_end, peak_*
//   config   | cfg_wr_en             | cfg_wr_data (half_size)
//
// After acceptance a transaction passes through two squarings, one after the other, a sum,
// 16 square-root steps of one bit each, then the hand-off to the result register. The
// sequencer returns to idle after the hand-off, and there the next transaction is accepted.
// in_ready is high only while the sequencer is idle; the output register holds a
// result while the next bin is already being worked on, and a stalled output holds
// the sequencer before publishing. Reset sets half_size to 512, clears the counter
// and the peak, and leaves the output empty.
module spectrum_magnitude_shift_peak
    import smsp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [HALF_W-1:0]          cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] re,
    input  logic signed [SAMPLE_W-1:0] im,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [IDX_W-1:0]           bin_index,
    output logic [MAG_W-1:0]           magnitude,
    output logic                       frame_end,
    output logic [IDX_W-1:0]           peak_index,
    output logic [MAG_W-1:0]           peak_magnitude
);

    cmd_t    cmd;
    status_t status;

    smsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    smsp_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .re             (re),
        .im             (im),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bin_index      (bin_index),
        .magnitude      (magnitude),
        .frame_end      (frame_end),
        .peak_index     (peak_index),
        .peak_magnitude (peak_magnitude)
    );

endmodule
